// ===== src/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator: request and
// result words, status and command codes, node evaluation flags.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int POOL_LOG2_DEF   = 20;
	localparam int TREE_LEVELS_DEF = 10;

	localparam logic [4:0] MIN_GRAIN_RESET = 5'd10;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_NOBLK = 2'd2
	} status_t;

	typedef struct packed {
		logic        command;
		logic [20:0] req_size;
		logic [4:0]  align_log2;
		logic [19:0] free_offset;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [19:0] block_offset;
		logic [20:0] block_size;
		logic [20:0] bytes_in_use;
	} rsp_t;

	typedef struct packed {
		logic minimal;
		logic bottom;
		logic misaligned;
		logic too_small;
		logic under_twice;
		logic go_right;
		logic off_match;
	} node_flags_t;

endpackage

// ===== src/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write port, single registered read port RAM.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bba_node_unit.sv =====
// ----------------------------------------------------------------------------
// bba_node_unit
// Shared node evaluator: offset and size of one tree node from its index
// and depth, plus the compares both the allocate and free walks need.
// ----------------------------------------------------------------------------
module bba_node_unit #(
	parameter int POOL_LOG2   = 20,
	parameter int TREE_LEVELS = 10
) (
	input  logic [TREE_LEVELS:0]   idx,
	input  logic [$clog2(((POOL_LOG2 > TREE_LEVELS) ? POOL_LOG2 : TREE_LEVELS) + 1)-1:0] dep,
	input  logic [20:0]            req,
	input  logic [4:0]             align,
	input  logic [4:0]             grain,
	input  logic [19:0]            addr,
	output logic [POOL_LOG2-1:0]   off,
	output logic [POOL_LOG2:0]     size,
	output bba_pkg::node_flags_t   flags
);
	import bba_pkg::*;

	localparam int IW   = TREE_LEVELS + 1;
	localparam int DMAX = (POOL_LOG2 > TREE_LEVELS) ? POOL_LOG2 : TREE_LEVELS;
	localparam int DW   = $clog2(DMAX + 1);
	localparam int SUMW = POOL_LOG2 + IW;
	localparam int CW   = (POOL_LOG2 + 1 > 22) ? POOL_LOG2 + 1 : 22;
	localparam int AW   = ((POOL_LOG2 > 20) ? POOL_LOG2 : 20) + 1;

	logic [IW-1:0]        pos;
	logic [DW-1:0]        sh;
	logic [SUMW-1:0]      off_w;
	logic [POOL_LOG2-1:0] amask;
	logic [AW-1:0]        mid;

	always_comb begin
		pos   = idx + IW'(1) - (IW'(1) << dep);
		sh    = DW'(POOL_LOG2) - dep;
		size  = (POOL_LOG2 + 1)'(1) << sh;
		off_w = SUMW'(pos) << sh;
		off   = off_w[POOL_LOG2-1:0];
		for (int j = 0; j < POOL_LOG2; j++) begin
			amask[j] = (32'(j) < 32'(align));
		end
		mid = AW'(off) + AW'(size >> 1);

		flags.bottom      = (32'(dep) >= TREE_LEVELS) || (32'(dep) >= POOL_LOG2);
		flags.minimal     = flags.bottom || ((POOL_LOG2 - 32'(dep)) <= 32'(grain));
		flags.misaligned  = |(off & amask);
		flags.too_small   = CW'(size) < CW'(req);
		flags.under_twice = CW'(size) < (CW'(req) << 1);
		flags.go_right    = AW'(addr) >= mid;
		flags.off_match   = AW'(off) == AW'(addr);
	end

endmodule

// ===== src/buddy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator over a power-of-two pool kept as a complete binary
// tree with per-node allocated and busy-below flags in two RAMs.
// ----------------------------------------------------------------------------
// Sequencing: allocate pops and evaluates each node visited, then marks
//   each ancestor busy; free reads and evaluates each level walked down,
//   then reads each ancestor, checks it, reads its children and rewrites
//   it. One shared node evaluator and one RAM read per cycle pace these steps.
// Throughput: one word in flight; the next is taken once the result is queued.
// Reset: a clearing pass over all 2^(TREE_LEVELS+1)-1 nodes (2047 by default)
//   zeroes the node RAMs; no word is accepted during it.
module buddy_block_allocator_core #(
	parameter int POOL_LOG2   = bba_pkg::POOL_LOG2_DEF,
	parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bba_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output bba_pkg::rsp_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [4:0]    cfg_data
);
	import bba_pkg::*;

	localparam int IW      = TREE_LEVELS + 1;
	localparam int NODES   = (2 ** IW) - 1;
	localparam int DMAX    = (POOL_LOG2 > TREE_LEVELS) ? POOL_LOG2 : TREE_LEVELS;
	localparam int DW      = $clog2(DMAX + 1);
	localparam int STACK_D = TREE_LEVELS + 1;
	localparam int SPW     = $clog2(STACK_D + 1);
	localparam int SIW     = $clog2(STACK_D);

	typedef enum logic [12:0] {
		S_CLEAR    = 13'b0000000000001,
		S_IDLE     = 13'b0000000000010,
		S_A_POP    = 13'b0000000000100,
		S_A_EVAL   = 13'b0000000001000,
		S_A_MARK   = 13'b0000000010000,
		S_F_READ   = 13'b0000000100000,
		S_F_EVAL   = 13'b0000001000000,
		S_F_UP_RD  = 13'b0000010000000,
		S_F_UP_CHK = 13'b0000100000000,
		S_F_UP_L   = 13'b0001000000000,
		S_F_UP_R   = 13'b0010000000000,
		S_DONE     = 13'b0100000000000,
		S_SPARE    = 13'b1000000000000
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   clr_q;
	logic [IW-1:0]   cur_i_q;
	logic [DW-1:0]   cur_d_q;
	logic [IW-1:0]   p_q;
	logic            left_q;
	logic [SPW-1:0]  sp_q;
	logic [IW-1:0]   stk_idx_q [STACK_D];
	logic [DW-1:0]   stk_dep_q [STACK_D];
	logic [20:0]     used_q;
	logic [4:0]      grain_q;
	logic [20:0]     req_q;
	logic [4:0]      align_q;
	logic [19:0]     addr_q;
	rsp_t            res_q;
	rsp_t            out_q;
	logic            out_valid_q;

	logic [POOL_LOG2-1:0] n_off;
	logic [POOL_LOG2:0]   n_size;
	node_flags_t          fl;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic          alloc_we;
	logic          alloc_wd;
	logic          busy_we;
	logic          busy_wd;
	logic          alloc_rd;
	logic          busy_rd;
	logic          take;
	logic          release_ok;
	logic [IW-1:0] par;
	logic [SIW-1:0] top;

	bba_node_unit #(
		.POOL_LOG2   (POOL_LOG2),
		.TREE_LEVELS (TREE_LEVELS)
	) u_node (
		.idx   (cur_i_q),
		.dep   (cur_d_q),
		.req   (req_q),
		.align (align_q),
		.grain (grain_q),
		.addr  (addr_q),
		.off   (n_off),
		.size  (n_size),
		.flags (fl)
	);

	bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_alloc_ram (
		.clk   (clk),
		.we    (alloc_we),
		.waddr (wr_addr),
		.wdata (alloc_wd),
		.raddr (rd_addr),
		.rdata (alloc_rd)
	);

	bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_busy_ram (
		.clk   (clk),
		.we    (busy_we),
		.waddr (wr_addr),
		.wdata (busy_wd),
		.raddr (rd_addr),
		.rdata (busy_rd)
	);

	assign par        = (p_q - IW'(1)) >> 1;
	assign top        = SIW'(sp_q - SPW'(1));
	assign take       = !fl.misaligned && !alloc_rd && !fl.too_small &&
	                    (fl.under_twice || fl.minimal) && !busy_rd;
	assign release_ok = alloc_rd && fl.off_match;

	always_comb begin
		rd_addr  = cur_i_q;
		wr_addr  = cur_i_q;
		alloc_we = 1'b0;
		alloc_wd = 1'b0;
		busy_we  = 1'b0;
		busy_wd  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_addr  = clr_q;
				alloc_we = 1'b1;
				busy_we  = 1'b1;
			end
			S_A_POP: begin
				rd_addr = stk_idx_q[top];
			end
			S_A_EVAL: begin
				if (take) begin
					alloc_we = 1'b1;
					alloc_wd = 1'b1;
					busy_we  = 1'b1;
					busy_wd  = 1'b1;
				end
			end
			S_A_MARK: begin
				wr_addr = par;
				busy_we = 1'b1;
				busy_wd = 1'b1;
			end
			S_F_EVAL: begin
				alloc_we = release_ok;
				busy_we  = release_ok;
			end
			S_F_UP_RD: begin
				rd_addr = par;
			end
			S_F_UP_CHK: begin
				rd_addr = (p_q << 1) + IW'(1);
			end
			S_F_UP_L: begin
				rd_addr = (p_q << 1) + IW'(2);
			end
			S_F_UP_R: begin
				wr_addr = p_q;
				busy_we = 1'b1;
				busy_wd = left_q | busy_rd;
			end
			default: begin
				rd_addr = cur_i_q;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q   <= in_data.req_size;
			align_q <= in_data.align_log2;
			addr_q  <= in_data.free_offset;
		end
		if (state_q == S_IDLE) begin
			stk_idx_q[0] <= '0;
			stk_dep_q[0] <= '0;
		end
		if (state_q == S_A_EVAL && !take && !fl.misaligned && !alloc_rd &&
		    !fl.too_small && !fl.minimal && (32'(sp_q) + 32'd2 <= STACK_D)) begin
			stk_idx_q[SIW'(sp_q)]          <= (cur_i_q << 1) + IW'(2);
			stk_dep_q[SIW'(sp_q)]          <= cur_d_q + DW'(1);
			stk_idx_q[SIW'(sp_q + SPW'(1))] <= (cur_i_q << 1) + IW'(1);
			stk_dep_q[SIW'(sp_q + SPW'(1))] <= cur_d_q + DW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cur_i_q     <= '0;
			cur_d_q     <= '0;
			p_q         <= '0;
			left_q      <= 1'b0;
			sp_q        <= '0;
			used_q      <= '0;
			grain_q     <= MIN_GRAIN_RESET;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				grain_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cur_i_q <= '0;
						cur_d_q <= '0;
						sp_q    <= SPW'(1);
						if (in_data.command == CMD_FREE) begin
							state_q <= S_F_READ;
						end else begin
							state_q <= S_A_POP;
						end
					end
				end
				S_A_POP: begin
					cur_i_q <= stk_idx_q[top];
					cur_d_q <= stk_dep_q[top];
					sp_q    <= sp_q - SPW'(1);
					state_q <= S_A_EVAL;
				end
				S_A_EVAL: begin
					if (fl.misaligned) begin
						res_q   <= '{ST_OOM, 20'd0, 21'd0, used_q};
						state_q <= S_DONE;
					end else if (take) begin
						used_q  <= used_q + 21'(n_size);
						res_q   <= '{ST_OK, 20'(n_off), 21'(n_size), used_q + 21'(n_size)};
						p_q     <= cur_i_q;
						state_q <= (cur_i_q == '0) ? S_DONE : S_A_MARK;
					end else begin
						// push right then left so the left child pops first
						if (!alloc_rd && !fl.too_small && !fl.minimal &&
						    (32'(sp_q) + 32'd2 <= STACK_D)) begin
							sp_q    <= sp_q + SPW'(2);
							state_q <= S_A_POP;
						end else if (sp_q == '0) begin
							res_q   <= '{ST_OOM, 20'd0, 21'd0, used_q};
							state_q <= S_DONE;
						end else begin
							state_q <= S_A_POP;
						end
					end
				end
				S_A_MARK: begin
					p_q <= par;
					if (par == '0) begin
						state_q <= S_DONE;
					end
				end
				S_F_READ: begin
					state_q <= S_F_EVAL;
				end
				S_F_EVAL: begin
					if (alloc_rd) begin
						if (fl.off_match) begin
							used_q  <= used_q - 21'(n_size);
							res_q   <= '{ST_OK, 20'(n_off), 21'(n_size), used_q - 21'(n_size)};
							p_q     <= cur_i_q;
							state_q <= (cur_i_q == '0) ? S_DONE : S_F_UP_RD;
						end else begin
							res_q   <= '{ST_NOBLK, 20'd0, 21'd0, used_q};
							state_q <= S_DONE;
						end
					end else if (fl.bottom) begin
						res_q   <= '{ST_NOBLK, 20'd0, 21'd0, used_q};
						state_q <= S_DONE;
					end else begin
						cur_i_q <= (cur_i_q << 1) + (fl.go_right ? IW'(2) : IW'(1));
						cur_d_q <= cur_d_q + DW'(1);
						state_q <= S_F_READ;
					end
				end
				S_F_UP_RD: begin
					p_q     <= par;
					state_q <= S_F_UP_CHK;
				end
				S_F_UP_CHK: begin
					// stop once an ancestor is already clear
					state_q <= busy_rd ? S_F_UP_L : S_DONE;
				end
				S_F_UP_L: begin
					left_q  <= busy_rd;
					state_q <= S_F_UP_R;
				end
				S_F_UP_R: begin
					if ((left_q | busy_rd) || p_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_UP_RD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= STACK_D)
		else $error("search stack overflow");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |->
			out_q.block_offset == '0 && out_q.block_size == '0)
		else $error("error result carries offset or size");

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall && !out_valid_q)
		else $error("activity during clearing pass");

	a_mark_nonroot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_MARK || state_q == S_F_UP_RD |-> p_q != '0)
		else $error("ancestor walk above root");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy allocator core testbench
// Sends allocate and free words, predicts each result from a tree model kept
// here, and compares results field by field under random stalls. It runs
// several granule settings and three idle patterns, and holds the output off
// for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;
	import bba_pkg::*;

	localparam int POOL = 20;
	localparam int LEVELS = 10;
	localparam int NODES = (1 << (LEVELS + 1)) - 1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	req_t       in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	rsp_t       out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data = '0;

	buddy_block_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// allocator model
	bit         tree_alloc [NODES];
	bit         tree_busy [NODES];
	logic [20:0] used_bytes;
	logic [4:0]  grain_log2;
	logic [19:0] live_blocks[$];

	req_t pending_words[$];
	rsp_t awaited_rsp[$];
	int   error_count = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   hold_req = 1'b0;
	bit   hold_on = 1'b0;

	function automatic int node_depth(int i);
		int d;
		int v;
		d = 0;
		v = i + 1;
		while (v > 1) begin
			v = v >> 1;
			d++;
		end
		return d;
	endfunction

	function automatic bit at_bottom(int d);
		return d >= LEVELS || d >= POOL || (POOL - d) <= int'(grain_log2);
	endfunction

	function automatic rsp_t make_rsp(status_t st, longint off, longint sz);
		rsp_t r;
		r.status = st;
		r.block_offset = off[19:0];
		r.block_size = sz[20:0];
		r.bytes_in_use = used_bytes;
		return r;
	endfunction

	function automatic rsp_t grant_block(logic [20:0] req, logic [4:0] align);
		int stk [LEVELS + 1];
		int sp;
		int i;
		int d;
		int p;
		longint off;
		longint sz;
		longint amask;
		bit bottom;
		amask = (64'd1 << align) - 1;
		sp = 0;
		stk[sp++] = 0;
		while (sp > 0) begin
			i = stk[--sp];
			d = node_depth(i);
			off = longint'(i + 1 - (1 << d)) << (POOL - d);
			sz = 64'd1 << (POOL - d);
			bottom = at_bottom(d);
			if ((off & amask) != 0)
				break;
			if (tree_alloc[i] || sz < req)
				continue;
			if ((sz < 2 * longint'(req) || bottom) && !tree_busy[i]) begin
				tree_alloc[i] = 1;
				tree_busy[i] = 1;
				p = i;
				while (p > 0) begin
					p = (p - 1) / 2;
					tree_busy[p] = 1;
				end
				used_bytes = used_bytes + sz[20:0];
				live_blocks.push_back(off[19:0]);
				return make_rsp(ST_OK, off, sz);
			end
			if (!bottom && sp + 2 <= LEVELS + 1) begin
				stk[sp++] = 2 * i + 2;
				stk[sp++] = 2 * i + 1;
			end
		end
		return make_rsp(ST_OOM, 0, 0);
	endfunction

	function automatic rsp_t release_block(logic [19:0] addr);
		int i;
		int d;
		longint off;
		longint half;
		longint sz;
		i = 0;
		d = 0;
		off = 0;
		while (!tree_alloc[i]) begin
			if (d >= LEVELS || d >= POOL)
				return make_rsp(ST_NOBLK, 0, 0);
			half = 64'd1 << (POOL - d - 1);
			if (addr >= off + half) begin
				off += half;
				i = 2 * i + 2;
			end else begin
				i = 2 * i + 1;
			end
			d++;
		end
		if (off != addr)
			return make_rsp(ST_NOBLK, 0, 0);
		sz = 64'd1 << (POOL - d);
		tree_alloc[i] = 0;
		tree_busy[i] = 0;
		used_bytes = used_bytes - sz[20:0];
		foreach (live_blocks[k])
			if (live_blocks[k] == addr) begin
				live_blocks.delete(k);
				break;
			end
		while (i > 0) begin
			i = (i - 1) / 2;
			if (!tree_busy[i])
				break;
			tree_busy[i] = tree_busy[2 * i + 1] | tree_busy[2 * i + 2];
			if (tree_busy[i])
				break;
		end
		return make_rsp(ST_OK, off, sz);
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	// driver: advance to the next word once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (in_data.command == CMD_ALLOC)
					awaited_rsp.push_back(grant_block(in_data.req_size, in_data.align_log2));
				else
					awaited_rsp.push_back(release_block(in_data.free_offset));
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_words[0];
					pending_words.delete(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// hold the output off for a long stretch once asked
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (600) @(posedge clk);
		hold_on <= 1'b0;
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_rsp.size() == 0) begin
					$display("unexpected result word at %0t", $realtime);
					error_count++;
				end else begin
					want = awaited_rsp[0];
					awaited_rsp.delete(0);
					if (out_data.status !== want.status)
						report_mismatch("status", out_data.status, want.status);
					if (out_data.block_offset !== want.block_offset)
						report_mismatch("block_offset", out_data.block_offset,
							want.block_offset);
					if (out_data.block_size !== want.block_size)
						report_mismatch("block_size", out_data.block_size, want.block_size);
					if (out_data.bytes_in_use !== want.bytes_in_use)
						report_mismatch("bytes_in_use", out_data.bytes_in_use,
							want.bytes_in_use);
				end
			end
			if (hold_on) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic req_t alloc_word(logic [20:0] sz, logic [4:0] al);
		req_t w;
		w = '0;
		w.command = CMD_ALLOC;
		w.req_size = sz;
		w.align_log2 = al;
		w.free_offset = 20'($urandom);
		return w;
	endfunction

	function automatic req_t free_word(logic [19:0] off);
		req_t w;
		w.command = CMD_FREE;
		w.req_size = 21'($urandom);
		w.align_log2 = 5'($urandom);
		w.free_offset = off;
		return w;
	endfunction

	function automatic req_t random_word();
		int pick;
		int k;
		pick = $urandom_range(99);
		if (pick < 50) begin
			k = $urandom_range(99);
			if (k < 3)
				return alloc_word(21'($urandom), 5'($urandom));
			if (k < 5)
				return alloc_word(21'd0, 5'($urandom_range(0, 12)));
			return alloc_word(21'($urandom_range(1, 1 << $urandom_range(0, 20))),
				($urandom_range(3) == 0) ? 5'($urandom_range(0, 20)) : 5'd0);
		end
		if (pick < 90 && live_blocks.size() > 0)
			return free_word(live_blocks[$urandom_range(live_blocks.size() - 1)]);
		if (pick < 95 && live_blocks.size() > 0)
			return free_word(live_blocks[$urandom_range(live_blocks.size() - 1)]
				+ 20'($urandom_range(1, 1023)));
		return free_word(20'($urandom));
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || awaited_rsp.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_grain(logic [4:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		grain_log2 = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [4:0] grains [7] = '{5'd10, 5'd20, 5'd0, 5'd31, 5'd14, 5'd12, 5'd10};
		used_bytes = '0;
		grain_log2 = MIN_GRAIN_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: edges of every field and each corner case
		pending_words.push_back(alloc_word(21'd1 << 20, 5'd0));
		pending_words.push_back(alloc_word(21'd1, 5'd0));
		pending_words.push_back(free_word(20'd0));
		pending_words.push_back(free_word(20'd0));
		pending_words.push_back(alloc_word(21'h1FFFFF, 5'd0));
		pending_words.push_back(alloc_word(21'd0, 5'd0));
		pending_words.push_back(alloc_word(21'd1, 5'd31));
		pending_words.push_back(alloc_word(21'd1, 5'd20));
		pending_words.push_back(alloc_word(21'd1500, 5'd12));
		pending_words.push_back(free_word(20'd1024));
		pending_words.push_back(free_word(20'hFFFFF));
		pending_words.push_back(alloc_word(21'd1 << 19, 5'd19));
		pending_words.push_back(alloc_word(21'd1 << 19, 5'd19));
		pending_words.push_back(alloc_word(21'd1 << 19, 5'd0));
		pending_words.push_back(free_word(20'h80000));
		pending_words.push_back(free_word(20'h80400));
		wait_drained();

		for (int ph = 0; ph < 7; ph++) begin
			write_grain(grains[ph]);
			if (ph < 3) begin
				send_idle_pct = 33;
				recv_idle_pct = 74;
			end else if (ph < 5) begin
				send_idle_pct = 74;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < 255; n++) begin
				while (pending_words.size() >= 2)
					@(negedge clk);
				pending_words.push_back(random_word());
				// hold the output off while the sender keeps offering
				if (ph == 5 && n == 40)
					hold_req = 1'b1;
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#300_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
